// ----- sv/imusc_pkg.sv -----
`timescale 1ns / 1ps

package imusc_pkg;

    localparam int AXES        = 3;
    localparam int RAW_W       = 16;
    localparam int GAIN_W      = 32;
    localparam int SCALED_W    = 48;
    localparam int BIAS_W      = 15;
    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 240;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_ACCEL_GAIN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GYRO_GAIN  = 1'b1;

    localparam logic KIND_ACCEL = 1'b0;
    localparam logic KIND_GYRO  = 1'b1;

    typedef logic signed [RAW_W-1:0]    t_raw;
    typedef logic signed [SCALED_W-1:0] t_scaled;
    typedef logic signed [BIAS_W-1:0]   t_bias;

    // midpoint of the tracked range, rounded toward minus infinity
    function automatic t_bias mid_floor(input t_raw hi, input t_raw lo);
        logic signed [RAW_W:0] sum;
        sum = {hi[RAW_W-1], hi} + {lo[RAW_W-1], lo};
        return sum[RAW_W-1:1];
    endfunction

endpackage

// ----- sv/imu_sample_convert_bias_track.sv -----
`timescale 1ns / 1ps

// IMU sample converter with accelerometer bias tracking.
// Input stream: s_axis_tdata carries six sensor bytes (x lo/hi, y lo/hi, z lo/hi),
// s_axis_tuser selects accelerometer (0) or gyroscope (1). Output stream:
// m_axis_tdata carries body counts, Q32.16 scaled values and the current
// accelerometer bias per axis; m_axis_tuser echoes the sample kind.
// Gains are set through the write port (index 0 accel, 1 gyro); the user must
// write them only while idle, which the block itself does not enforce. Two
// register stages: a request accepted into the stage register moves on to the
// output register when that is free. One request per cycle is sustained while
// the receiver is ready; the per-axis 16x32 multiply and min/max compare lie
// between the stage register and the output register. On a receiver stall the
// output register holds; the stage register takes a request only if it is empty.
// Reset clears both valid flags, the gains, and the per-axis maximum,
// minimum and bias (all zero). Gyro samples leave the tracking state alone.
module imu_sample_convert_bias_track
    import imusc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [GAIN_W-1:0]     i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // x_low_byte, x_high_byte, y_low_byte, y_high_byte, z_low_byte, z_high_byte
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // body_x_raw, body_y_raw, body_z_raw, scaled_x, scaled_y, scaled_z,
    // bias_x, bias_y, bias_z, 3 zero pad bits
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic                  m_axis_tuser
);

    logic [GAIN_W-1:0] r_accel_gain;
    logic [GAIN_W-1:0] r_gyro_gain;

    logic                 r_s1_valid;
    logic                 r_s1_kind;
    logic [IN_DATA_W-1:0] r_s1_data;

    logic                  r_out_valid;
    logic                  r_out_kind;
    logic [OUT_DATA_W-1:0] r_out_data;

    t_raw  r_max [AXES];
    t_raw  r_min [AXES];
    t_bias r_bias [AXES];
    t_raw  n_max [AXES];
    t_raw  n_min [AXES];
    t_bias n_bias [AXES];

    t_raw    body [AXES];
    t_scaled scaled [AXES];
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [GAIN_W-1:0]     gain;
    logic                  advance;

    assign advance       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || advance;
    assign gain          = (r_s1_kind == KIND_GYRO) ? r_gyro_gain : r_accel_gain;

    always_comb begin
        logic [RAW_W-1:0]    word;
        logic signed [SCALED_W:0] prod;
        for (int i = 0; i < AXES; i++) begin
            word = r_s1_data[2*i*8 +: RAW_W];
            // negation wraps, so the most negative count maps to itself
            body[i] = (i == 0) ? t_raw'(word) : t_raw'(RAW_W'(0) - word);
            prod = body[i] * $signed({1'b0, gain});
            scaled[i] = prod[SCALED_W-1:0];

            n_max[i]  = r_max[i];
            n_min[i]  = r_min[i];
            n_bias[i] = r_bias[i];
            if (r_s1_kind == KIND_ACCEL) begin
                if (body[i] > r_max[i]) begin
                    n_max[i]  = body[i];
                    n_bias[i] = mid_floor(body[i], r_min[i]);
                end else if (body[i] < r_min[i]) begin
                    n_min[i]  = body[i];
                    n_bias[i] = mid_floor(r_max[i], body[i]);
                end
            end
        end

        n_out_data = '0;
        for (int i = 0; i < AXES; i++) begin
            n_out_data[i*RAW_W +: RAW_W] = body[i];
            n_out_data[AXES*RAW_W + i*SCALED_W +: SCALED_W] = scaled[i];
            n_out_data[AXES*(RAW_W+SCALED_W) + i*BIAS_W +: BIAS_W] = n_bias[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_gain <= '0;
            r_gyro_gain  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ACCEL_GAIN: r_accel_gain <= i_cfg_wdata;
                REG_GYRO_GAIN:  r_gyro_gain  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1_kind <= s_axis_tuser;
            r_s1_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_max[i]  <= '0;
                r_min[i]  <= '0;
                r_bias[i] <= '0;
            end
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                for (int i = 0; i < AXES; i++) begin
                    r_max[i]  <= n_max[i];
                    r_min[i]  <= n_min[i];
                    r_bias[i] <= n_bias[i];
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_kind <= r_s1_kind;
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = r_out_data;

    // tracked range always straddles zero
    a_range_straddles_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max[0] >= 0 && r_min[0] <= 0 && r_max[1] >= 0 && r_min[1] <= 0 &&
        r_max[2] >= 0 && r_min[2] <= 0)
        else $error("tracked maximum or minimum crossed zero");

    // bias always matches the tracked midpoint
    a_bias_is_midpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bias[0] == mid_floor(r_max[0], r_min[0]) &&
        r_bias[1] == mid_floor(r_max[1], r_min[1]) &&
        r_bias[2] == mid_floor(r_max[2], r_min[2]))
        else $error("bias out of step with tracked range");

    // gyro samples leave tracking state untouched
    a_gyro_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_s1_kind == KIND_GYRO |=>
            $stable(r_max[0]) && $stable(r_min[0]) && $stable(r_max[1]) &&
            $stable(r_min[1]) && $stable(r_max[2]) && $stable(r_min[2]))
        else $error("gyro sample changed tracking state");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("output register changed while stalled");

endmodule
